// ----- rtl/gmn_pkg.sv -----
// ----------------------------------------------------------------------------
// gmn_pkg
// Shared constants, types and tables of the gradient magnitude and
// non-maximum suppression block.
// ----------------------------------------------------------------------------
package gmn_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int ROW_SLOTS  = 5;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int SLOT_W     = $clog2(ROW_SLOTS);
  localparam int PIX_DEPTH  = ROW_SLOTS * MAX_WIDTH;
  localparam int PIX_ADDR_W = $clog2(PIX_DEPTH);
  localparam int FW_W       = 11;
  localparam int FH_W       = 12;
  localparam int POS_W      = 22;
  localparam int LAG_W      = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;
  localparam int PIX_W      = 8;
  localparam int GRAD_W     = 9;
  localparam int SQ_W       = 17;
  localparam int MAG_W      = 9;
  localparam int PROD_W     = 17;
  localparam int WIN_SIZE   = 25;
  localparam int WIN_W      = $clog2(WIN_SIZE);
  localparam int NB_SIZE    = 9;
  localparam int NB_W       = $clog2(NB_SIZE);
  localparam int NB_CENTRE  = 4;

  localparam logic [FW_W-1:0] WIDTH_RESET  = FW_W'(640);
  localparam logic [FH_W-1:0] HEIGHT_RESET = FH_W'(480);
  localparam logic [FW_W-1:0] WIDTH_MIN    = FW_W'(3);
  localparam logic [FW_W-1:0] WIDTH_MAX    = FW_W'(MAX_WIDTH);
  localparam logic [FH_W-1:0] HEIGHT_MIN   = FH_W'(3);
  localparam logic [PIX_W-1:0] STRENGTH_MAX = PIX_W'(255);

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_DRAIN = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SETTLE,
    ST_SQUARE,
    ST_ROOT,
    ST_NMS_A,
    ST_NMS_B,
    ST_NMS_C,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic             done;
    logic [MAG_W-1:0] root;
  } sqrt_res_t;

  typedef struct packed {
    logic [NB_W-1:0] a1;
    logic [NB_W-1:0] b1;
    logic [NB_W-1:0] a2;
    logic [NB_W-1:0] b2;
  } nbr_t;

  // neighbour index = (row offset + 1) * 3 + (column offset + 1)
  function automatic nbr_t nbr_sel(input logic [2:0] dir);
    nbr_t n;
    case (dir)
      3'd0:    n = '{a1: NB_W'(5), b1: NB_W'(8), a2: NB_W'(3), b2: NB_W'(0)};
      3'd1:    n = '{a1: NB_W'(7), b1: NB_W'(8), a2: NB_W'(1), b2: NB_W'(0)};
      3'd2:    n = '{a1: NB_W'(5), b1: NB_W'(2), a2: NB_W'(3), b2: NB_W'(6)};
      3'd3:    n = '{a1: NB_W'(7), b1: NB_W'(6), a2: NB_W'(1), b2: NB_W'(2)};
      3'd4:    n = '{a1: NB_W'(7), b1: NB_W'(6), a2: NB_W'(1), b2: NB_W'(2)};
      3'd5:    n = '{a1: NB_W'(3), b1: NB_W'(6), a2: NB_W'(5), b2: NB_W'(2)};
      3'd6:    n = '{a1: NB_W'(3), b1: NB_W'(0), a2: NB_W'(5), b2: NB_W'(8)};
      3'd7:    n = '{a1: NB_W'(1), b1: NB_W'(0), a2: NB_W'(7), b2: NB_W'(8)};
      default: n = '{a1: NB_W'(5), b1: NB_W'(8), a2: NB_W'(3), b2: NB_W'(0)};
    endcase
    return n;
  endfunction

endpackage

// ----- rtl/gmn_ram.sv -----
// ----------------------------------------------------------------------------
// gmn_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module gmn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/gmn_sqrt.sv -----
// ----------------------------------------------------------------------------
// gmn_sqrt
// Iterative rounded integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module gmn_sqrt import gmn_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SQ_W-1:0] radicand_i,
  output sqrt_res_t       res_o
);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [SQ_W-1:0] rem_q, rem_d;
  logic [SQ_W-1:0] root_q, root_d;
  logic [SQ_W-1:0] bit_q, bit_d;
  logic [MAG_W-1:0] res_q, res_d;
  logic [SQ_W:0]   trial;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    res_d  = res_q;
    trial  = {1'b0, root_q} + {1'b0, bit_q};
    if (start_i) begin
      busy_d = 1'b1;
      rem_d  = radicand_i;
      root_d = '0;
      bit_d  = SQ_W'(1) << (SQ_W - 1);
    end else if (busy_q) begin
      if (bit_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        res_d  = MAG_W'(root_q) + MAG_W'(rem_q > root_q);
      end else begin
        if ({1'b0, rem_q} >= trial) begin
          rem_d  = SQ_W'({1'b0, rem_q} - trial);
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
    bit_q  <= bit_d;
    res_q  <= res_d;
  end

  assign res_o.done = done_q;
  assign res_o.root = res_q;

endmodule

// ----- rtl/gradient_magnitude_nms_top.sv -----
// ----------------------------------------------------------------------------
// gradient_magnitude_nms_top
// Streaming gradient magnitude with interpolated non-maximum suppression.
// ----------------------------------------------------------------------------
// Pixels enter in raster order and are stored in a five-row line memory.
// Requests that produce no result (early pixels, early drains) are taken
// while the block stays idle. A border pixel goes from acceptance straight
// to the output step. An inner pixel passes through acceptance, one
// decision step, 25 reads of the line memory port to build a 5x5 window,
// one settle step, a square step and a root step for each of the nine
// magnitudes of the 3x3 neighbourhood in the shared iterative square-root
// unit, three suppression steps and the output step. The output step waits
// while a stalled result still holds the output register. A result lags its
// pixel by 2*width+2 requests; once the frame is complete every request
// flushes one result. A frame width or height write restarts the frame.
module gradient_magnitude_nms_top import gmn_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  func_i,
  input  logic [PIX_W-1:0]      pixel_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [PIX_W-1:0]      edge_strength_o,
  output logic                  last_of_frame_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [FW_W-1:0]   frame_width_q;
  logic [FH_W-1:0]   frame_height_q;
  logic [FW_W-1:0]   w_eff;
  logic [FH_W-1:0]   h_eff;
  logic [COL_W-1:0]  wm1;
  logic [FH_W-1:0]   hm1;
  logic [POS_W-1:0]  total;
  logic [LAG_W-1:0]  lag;

  logic [POS_W-1:0]  in_pos_q;
  logic [COL_W-1:0]  in_col_q;
  logic [SLOT_W-1:0] in_slot_q;
  logic [COL_W-1:0]  out_col_q;
  logic [FH_W-1:0]   out_row_q;
  logic [SLOT_W-1:0] out_slot_q;

  logic [COL_W-1:0]  cur_col_q;
  logic [FH_W-1:0]   cur_row_q;
  logic [SLOT_W-1:0] cur_slot_q;
  logic              cur_last_q;
  logic              cur_inner;

  logic accept, in_phase, is_pixel, emit, out_last, cfg_hit, out_take;

  logic [2:0]       rd_r_q, rd_c_q;
  logic [WIN_W-1:0] rd_cnt_q, widx_q;
  logic             cap_q;
  logic [PIX_W-1:0] win_q [WIN_SIZE];

  logic signed [FH_W+1:0]  row_s;
  logic signed [COL_W+1:0] col_s;
  logic [FH_W-1:0]         row_abs;
  logic [COL_W-1:0]        col_abs;
  logic [2:0]              row_delta;
  logic [3:0]              slot_sum;
  logic [SLOT_W-1:0]       rd_slot;

  logic                     pix_we, pix_re;
  logic [PIX_ADDR_W-1:0]    pix_waddr, pix_raddr;
  logic [PIX_W-1:0]         pix_rdata;

  logic signed [GRAD_W-1:0] dxs [NB_SIZE];
  logic signed [GRAD_W-1:0] dys [NB_SIZE];
  logic signed [GRAD_W-1:0] dx_sel, dy_sel, cdx, cdy;
  logic signed [2*GRAD_W-1:0] dx2, dy2;
  logic [SQ_W-1:0]          radicand;
  logic [NB_W-1:0]          mag_j_q;
  logic [MAG_W-1:0]         mag_q [NB_SIZE];
  sqrt_res_t                sqrt_res;
  logic                     sqrt_start;

  logic signed [GRAD_W:0]   sum_xy, diff_yx;
  logic [PIX_W-1:0]         q_v, p_v;
  logic [2:0]               dir;
  nbr_t                     nb;
  logic [PROD_W-1:0]        qm_q, pa_q, pb_q;
  logic                     sup1_q;
  logic                     sup_now;
  logic [PIX_W-1:0]         res_q;
  logic                     res_last_q;
  logic                     out_load;
  logic [PIX_W-1:0]         out_data_q;
  logic                     out_last_q;
  logic                     out_valid_q;
  logic                     fin_ready, fin_ready_q;

  // --- configuration and frame geometry ---
  assign w_eff = (frame_width_q < WIDTH_MIN) ? WIDTH_MIN :
                 (frame_width_q > WIDTH_MAX) ? WIDTH_MAX : frame_width_q;
  assign h_eff = (frame_height_q < HEIGHT_MIN) ? HEIGHT_MIN : frame_height_q;
  assign wm1   = COL_W'(w_eff - FW_W'(1));
  assign hm1   = h_eff - FH_W'(1);
  assign total = POS_W'(w_eff * h_eff);
  assign lag   = LAG_W'({w_eff, 1'b0}) + LAG_W'(2);

  assign cfg_hit  = cfg_we_i && (cfg_index_i == REG_FRAME_WIDTH ||
                                 cfg_index_i == REG_FRAME_HEIGHT);
  assign accept   = in_valid_i && !in_stall_o;
  assign in_phase = in_pos_q < total;
  assign is_pixel = (func_i == FUNC_PIXEL);
  assign emit     = in_phase ? (is_pixel && in_pos_q >= POS_W'(lag)) : 1'b1;
  assign out_last = (out_row_q == hm1) && (out_col_q == wm1);
  assign cur_inner = (cur_row_q != '0) && (cur_row_q != hm1) &&
                     (cur_col_q != '0) && (cur_col_q != wm1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= WIDTH_RESET;
      frame_height_q <= HEIGHT_RESET;
      in_pos_q       <= '0;
      in_col_q       <= '0;
      in_slot_q      <= '0;
      out_col_q      <= '0;
      out_row_q      <= '0;
      out_slot_q     <= '0;
    end else if (cfg_hit) begin
      if (cfg_index_i == REG_FRAME_WIDTH) begin
        frame_width_q <= cfg_data_i[FW_W-1:0];
      end else begin
        frame_height_q <= cfg_data_i[FH_W-1:0];
      end
      in_pos_q   <= '0;
      in_col_q   <= '0;
      in_slot_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
    end else if (accept) begin
      if (in_phase && is_pixel) begin
        in_pos_q <= in_pos_q + POS_W'(1);
        if (in_col_q == wm1) begin
          in_col_q  <= '0;
          in_slot_q <= (in_slot_q == SLOT_W'(ROW_SLOTS - 1)) ? '0 : in_slot_q + SLOT_W'(1);
        end else begin
          in_col_q <= in_col_q + COL_W'(1);
        end
      end
      if (emit) begin
        if (out_last) begin
          in_pos_q   <= '0;
          in_col_q   <= '0;
          in_slot_q  <= '0;
          out_col_q  <= '0;
          out_row_q  <= '0;
          out_slot_q <= '0;
        end else if (out_col_q == wm1) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_q + FH_W'(1);
          out_slot_q <= (out_slot_q == SLOT_W'(ROW_SLOTS - 1)) ? '0 :
                        out_slot_q + SLOT_W'(1);
        end else begin
          out_col_q <= out_col_q + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      cur_col_q  <= out_col_q;
      cur_row_q  <= out_row_q;
      cur_slot_q <= out_slot_q;
      cur_last_q <= out_last;
    end
  end

  // --- line memory ---
  assign pix_we    = accept && in_phase && is_pixel;
  assign pix_waddr = PIX_ADDR_W'({in_slot_q, in_col_q});

  always_comb begin
    row_s = $signed({2'b00, cur_row_q}) + $signed((FH_W+2)'(rd_r_q)) - (FH_W+2)'(2);
    col_s = $signed({2'b00, cur_col_q}) + $signed((COL_W+2)'(rd_c_q)) - (COL_W+2)'(2);
    if (row_s < 0) begin
      row_abs = '0;
    end else if (row_s > $signed({2'b00, hm1})) begin
      row_abs = hm1;
    end else begin
      row_abs = row_s[FH_W-1:0];
    end
    if (col_s < 0) begin
      col_abs = '0;
    end else if (col_s > $signed({2'b00, wm1})) begin
      col_abs = wm1;
    end else begin
      col_abs = col_s[COL_W-1:0];
    end
    row_delta = 3'(row_abs - cur_row_q);
    slot_sum  = 4'(cur_slot_q) + 4'(ROW_SLOTS) + {row_delta[2], row_delta};
    if (slot_sum >= 4'(2 * ROW_SLOTS)) begin
      rd_slot = SLOT_W'(slot_sum - 4'(2 * ROW_SLOTS));
    end else if (slot_sum >= 4'(ROW_SLOTS)) begin
      rd_slot = SLOT_W'(slot_sum - 4'(ROW_SLOTS));
    end else begin
      rd_slot = SLOT_W'(slot_sum);
    end
  end

  assign pix_raddr = PIX_ADDR_W'({rd_slot, col_abs});

  gmn_ram #(
    .WIDTH (PIX_W),
    .DEPTH (PIX_DEPTH)
  ) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (pix_waddr),
    .wdata_i (pixel_i),
    .re_i    (pix_re),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= 1'b0;
    end else begin
      cap_q <= pix_re;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE) begin
      rd_r_q   <= '0;
      rd_c_q   <= '0;
      rd_cnt_q <= '0;
    end else if (pix_re) begin
      rd_cnt_q <= rd_cnt_q + WIN_W'(1);
      if (rd_c_q == 3'd4) begin
        rd_c_q <= '0;
        rd_r_q <= rd_r_q + 3'd1;
      end else begin
        rd_c_q <= rd_c_q + 3'd1;
      end
    end
    widx_q <= rd_cnt_q;
    if (cap_q) begin
      win_q[widx_q] <= pix_rdata;
    end
  end

  // --- gradients and magnitudes ---
  always_comb begin
    for (int jr = 0; jr < 3; jr++) begin
      for (int jc = 0; jc < 3; jc++) begin
        dxs[jr*3+jc] = $signed({1'b0, win_q[(jr+1)*5 + jc + 2]}) -
                       $signed({1'b0, win_q[(jr+1)*5 + jc]});
        dys[jr*3+jc] = $signed({1'b0, win_q[(jr+2)*5 + jc + 1]}) -
                       $signed({1'b0, win_q[jr*5 + jc + 1]});
      end
    end
  end

  assign dx_sel   = dxs[mag_j_q];
  assign dy_sel   = dys[mag_j_q];
  assign dx2      = dx_sel * dx_sel;
  assign dy2      = dy_sel * dy_sel;
  assign radicand = SQ_W'(dx2 + dy2);

  gmn_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (radicand),
    .res_o      (sqrt_res)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == ST_SETTLE) begin
      mag_j_q <= '0;
    end else if (state_q == ST_ROOT && sqrt_res.done) begin
      mag_q[mag_j_q] <= sqrt_res.root;
      mag_j_q        <= mag_j_q + NB_W'(1);
    end
  end

  // --- direction and suppression ---
  assign cdx     = dxs[NB_CENTRE];
  assign cdy     = dys[NB_CENTRE];
  assign sum_xy  = GRAD_W'(1) == 0 ? '0 : ($signed({cdx[GRAD_W-1], cdx}) +
                                           $signed({cdy[GRAD_W-1], cdy}));
  assign diff_yx = $signed({cdy[GRAD_W-1], cdy}) - $signed({cdx[GRAD_W-1], cdx});

  always_comb begin
    if (cdx >= 0) begin
      if (cdy >= 0) begin
        if (cdx >= cdy) begin
          dir = 3'd0; q_v = PIX_W'(cdx); p_v = PIX_W'(cdy);
        end else begin
          dir = 3'd1; q_v = PIX_W'(cdy); p_v = PIX_W'(cdx);
        end
      end else begin
        if (sum_xy >= 0) begin
          dir = 3'd2; q_v = PIX_W'(cdx); p_v = PIX_W'(-cdy);
        end else begin
          dir = 3'd3; q_v = PIX_W'(-cdy); p_v = PIX_W'(cdx);
        end
      end
    end else begin
      if (cdy >= 0) begin
        if (sum_xy >= 0) begin
          dir = 3'd4; q_v = PIX_W'(cdy); p_v = PIX_W'(-cdx);
        end else begin
          dir = 3'd5; q_v = PIX_W'(-cdx); p_v = PIX_W'(cdy);
        end
      end else begin
        if (diff_yx >= 0) begin
          dir = 3'd6; q_v = PIX_W'(-cdx); p_v = PIX_W'(-cdy);
        end else begin
          dir = 3'd7; q_v = PIX_W'(-cdy); p_v = PIX_W'(-cdx);
        end
      end
    end
    nb = nbr_sel(dir);
  end

  assign sup_now = ({1'b0, qm_q} < ({1'b0, pa_q} + {1'b0, pb_q}));

  always_ff @(posedge clk_i) begin
    qm_q <= PROD_W'(q_v * mag_q[NB_CENTRE]);
    if (state_q == ST_NMS_A) begin
      pa_q <= PROD_W'((q_v - p_v) * mag_q[nb.a1]);
      pb_q <= PROD_W'(p_v * mag_q[nb.b1]);
    end else begin
      pa_q <= PROD_W'((q_v - p_v) * mag_q[nb.a2]);
      pb_q <= PROD_W'(p_v * mag_q[nb.b2]);
    end
    if (state_q == ST_NMS_B) begin
      sup1_q <= sup_now;
    end
    if (state_q == ST_IDLE) begin
      res_q      <= '0;
      res_last_q <= out_last;
    end else if (state_q == ST_NMS_C) begin
      if (sup1_q || sup_now) begin
        res_q <= '0;
      end else if (mag_q[NB_CENTRE] > MAG_W'(STRENGTH_MAX)) begin
        res_q <= STRENGTH_MAX;
      end else begin
        res_q <= PIX_W'(mag_q[NB_CENTRE]);
      end
      res_last_q <= cur_last_q;
    end
  end

  // --- output register ---
  assign out_take = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cfg_hit) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= res_q;
      out_last_q <= res_last_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign edge_strength_o = out_data_q;
  assign last_of_frame_o = out_last_q;

  // --- sequencer ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && emit) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end else if (!fin_ready) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        if (rd_cnt_q == WIN_W'(WIN_SIZE - 1)) begin
          state_d = ST_SETTLE;
        end
      end
      ST_SETTLE: state_d = ST_SQUARE;
      ST_SQUARE: state_d = ST_ROOT;
      ST_ROOT: begin
        if (sqrt_res.done) begin
          state_d = (mag_j_q == NB_W'(NB_SIZE - 1)) ? ST_NMS_A : ST_SQUARE;
        end
      end
      ST_NMS_A: state_d = ST_NMS_B;
      ST_NMS_B: state_d = ST_NMS_C;
      ST_NMS_C: state_d = ST_FIN;
      default:  state_d = ST_IDLE;
    endcase
    if (cfg_hit) begin
      state_d = ST_IDLE;
    end
  end

  always_comb begin
    in_stall_o = 1'b1;
    pix_re     = 1'b0;
    sqrt_start = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE:   in_stall_o = 1'b0;
      ST_READ:   pix_re     = 1'b1;
      ST_SQUARE: sqrt_start = 1'b1;
      ST_FIN:    out_load   = fin_ready && (!out_valid_q || !out_stall_i);
      default:   in_stall_o = 1'b1;
    endcase
  end

  // a border pixel is resolved at once; an inner pixel goes through the window
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_ready_q <= 1'b0;
    end else if (state_q == ST_NMS_C) begin
      fin_ready_q <= 1'b1;
    end else if (state_q == ST_IDLE || state_q == ST_READ) begin
      fin_ready_q <= 1'b0;
    end
  end

  assign fin_ready = !cur_inner || fin_ready_q;

endmodule

// ----- rtl/gmn_checker.sv -----
// ----------------------------------------------------------------------------
// gmn_checker
// Port-level checks of the gradient magnitude and suppression block.
// ----------------------------------------------------------------------------
module gmn_checker import gmn_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [PIX_W-1:0]      edge_strength_o,
  input logic                  cfg_we_i,
  input logic [CFG_IDX_W-1:0]  cfg_index_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(edge_strength_o))
    else $error("stalled result changed");

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without the block being busy");

  a_cfg_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && (cfg_index_i == REG_FRAME_WIDTH || cfg_index_i == REG_FRAME_HEIGHT)
    |=> !out_valid_o)
    else $error("pending result survived a register write");

endmodule

bind gradient_magnitude_nms_top gmn_checker u_gmn_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .edge_strength_o (edge_strength_o),
  .cfg_we_i        (cfg_we_i),
  .cfg_index_i     (cfg_index_i)
);
